### rtl/mmfa_pkg.sv
// ----------------------------------------------------------------------------
// mmfa_pkg
// Shared constants for the Mueller-matrix-from-amplitudes block: default
// widths, convention codes, row codes, term layout and element pair table.
// ----------------------------------------------------------------------------
package mmfa_pkg;

  // default input part width and derived output width
  localparam int unsigned MMFA_IN_WIDTH  = 18;
  localparam int unsigned MMFA_OUT_WIDTH = 2 * MMFA_IN_WIDTH + 2;

  // convention codes
  localparam logic CONV_BH   = 1'b0;
  localparam logic CONV_TMAT = 1'b1;

  // row codes
  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_1     = 2'd1;
  localparam logic [1:0] ROW_2     = 2'd2;
  localparam logic [1:0] ROW_LAST  = 2'd3;

  // amplitude elements: a = s00, b = s01, c = s10, d = s11
  localparam int unsigned NUM_ELEMS = 4;
  localparam int unsigned ELEM_A = 0;
  localparam int unsigned ELEM_B = 1;
  localparam int unsigned ELEM_C = 2;
  localparam int unsigned ELEM_D = 3;

  // element pairs (x, y) with x before y
  localparam int unsigned NUM_PAIRS = 6;
  localparam int unsigned PAIR_AB = 0;
  localparam int unsigned PAIR_AC = 1;
  localparam int unsigned PAIR_AD = 2;
  localparam int unsigned PAIR_BC = 3;
  localparam int unsigned PAIR_BD = 4;
  localparam int unsigned PAIR_CD = 5;

  // term layout in the queue word: norms, then re(x*conj y), then im(x*conj y)
  localparam int unsigned TERM_NORM0 = 0;
  localparam int unsigned TERM_RE0   = TERM_NORM0 + NUM_ELEMS;
  localparam int unsigned TERM_IM0   = TERM_RE0 + NUM_PAIRS;
  localparam int unsigned NUM_TERMS  = TERM_IM0 + NUM_PAIRS;

  // queue depth between front and back
  localparam int unsigned MMFA_QUEUE_DEPTH = 2;

  // first element of a pair
  function automatic int unsigned pair_x(input int unsigned p);
    case (p)
      PAIR_AB, PAIR_AC, PAIR_AD: return ELEM_A;
      PAIR_BC, PAIR_BD:          return ELEM_B;
      default:                   return ELEM_C;
    endcase
  endfunction

  // second element of a pair
  function automatic int unsigned pair_y(input int unsigned p);
    case (p)
      PAIR_AB:          return ELEM_B;
      PAIR_AC, PAIR_BC: return ELEM_C;
      default:          return ELEM_D;
    endcase
  endfunction

endpackage

### rtl/mmfa_if.sv
// ----------------------------------------------------------------------------
// mmfa channel interfaces
// Valid/ready channels for the amplitude matrix, the Mueller rows and the
// convention register write.
// ----------------------------------------------------------------------------

// amplitude matrix channel
interface mmfa_amp_if import mmfa_pkg::*; #(
  parameter int unsigned IW = MMFA_IN_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic signed [IW-1:0] amp00_re;
  logic signed [IW-1:0] amp00_im;
  logic signed [IW-1:0] amp01_re;
  logic signed [IW-1:0] amp01_im;
  logic signed [IW-1:0] amp10_re;
  logic signed [IW-1:0] amp10_im;
  logic signed [IW-1:0] amp11_re;
  logic signed [IW-1:0] amp11_im;

  modport source (
    output valid, amp00_re, amp00_im, amp01_re, amp01_im,
           amp10_re, amp10_im, amp11_re, amp11_im,
    input  ready
  );
  modport sink (
    input  valid, amp00_re, amp00_im, amp01_re, amp01_im,
           amp10_re, amp10_im, amp11_re, amp11_im,
    output ready
  );
endinterface

// mueller row channel
interface mmfa_row_if import mmfa_pkg::*; #(
  parameter int unsigned OW = MMFA_OUT_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           row_index;
  logic signed [OW-1:0] elem_col0;
  logic signed [OW-1:0] elem_col1;
  logic signed [OW-1:0] elem_col2;
  logic signed [OW-1:0] elem_col3;
  logic                 last_row;

  modport source (
    output valid, row_index, elem_col0, elem_col1, elem_col2, elem_col3, last_row,
    input  ready
  );
  modport sink (
    input  valid, row_index, elem_col0, elem_col1, elem_col2, elem_col3, last_row,
    output ready
  );
endinterface

// convention register write channel
interface mmfa_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/mueller_matrix_from_amplitudes.sv
// ----------------------------------------------------------------------------
// mueller_matrix_from_amplitudes
// Mueller matrix from a complex 2x2 amplitude scattering matrix, emitted as
// four row words per input matrix.
//
//   channel   dir   handshake      word
//   cfg_i     in    valid/ready    convention bit (0 bohren-huffman, 1 t-matrix)
//   amp_i     in    valid/ready    eight signed parts of the amplitude matrix
//   row_o     out   valid/ready    row index, four mueller elements, last flag
//
// The row sequencer in the back end emits one row per cycle while row_o is
// not stalled and holds the queue head for four rows.
// From input to first row a matrix passes two product stages, the queue and
// the row register.
// The front end keeps taking matrices into a two-entry queue while rows wait.
// Reset clears the pipeline, queue and convention (bohren-huffman); no sweep.
// ----------------------------------------------------------------------------
module mueller_matrix_from_amplitudes import mmfa_pkg::*; #(
  parameter int unsigned IN_WIDTH = MMFA_IN_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mmfa_cfg_if.sink   cfg_i,
  mmfa_amp_if.sink   amp_i,
  mmfa_row_if.source row_o
);

  localparam int unsigned SW = 2 * IN_WIDTH + 1;
  localparam int unsigned TW = NUM_TERMS * SW + 1;

  logic [TW-1:0] front_terms, back_terms;
  logic          front_valid, front_ready;
  logic          back_valid, back_ready;

  // products and terms
  mmfa_front #(
    .IN_WIDTH (IN_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_i),
    .amp_i         (amp_i),
    .terms_o       (front_terms),
    .terms_valid_o (front_valid),
    .terms_ready_i (front_ready)
  );

  // decoupling queue
  mmfa_fifo #(
    .WIDTH (TW),
    .DEPTH (MMFA_QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_terms),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (back_terms),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  // row sequencer
  mmfa_back #(
    .IN_WIDTH (IN_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .terms_i       (back_terms),
    .terms_valid_i (back_valid),
    .terms_ready_o (back_ready),
    .row_o         (row_o)
  );

endmodule

### rtl/mmfa_front.sv
// ----------------------------------------------------------------------------
// mmfa_front
// Accepts amplitude matrices, tags each with the current convention and
// forms the sixteen magnitude and cross-product terms in two stages.
// ----------------------------------------------------------------------------
module mmfa_front import mmfa_pkg::*; #(
  parameter int unsigned IN_WIDTH = MMFA_IN_WIDTH,
  localparam int unsigned PW = 2 * IN_WIDTH,
  localparam int unsigned SW = 2 * IN_WIDTH + 1,
  localparam int unsigned TW = NUM_TERMS * SW + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mmfa_cfg_if.sink      cfg_i,
  mmfa_amp_if.sink      amp_i,
  output logic [TW-1:0] terms_o,
  output logic          terms_valid_o,
  input  logic          terms_ready_i
);

  logic                       conv_q;
  logic                       s1_valid_q, s2_valid_q;
  logic                       adv1, adv2;
  logic signed [IN_WIDTH-1:0] re_e [NUM_ELEMS];
  logic signed [IN_WIDTH-1:0] im_e [NUM_ELEMS];
  logic signed [PW-1:0]       sq_re_q [NUM_ELEMS];
  logic signed [PW-1:0]       sq_im_q [NUM_ELEMS];
  logic signed [PW-1:0]       rr_q [NUM_PAIRS];
  logic signed [PW-1:0]       ii_q [NUM_PAIRS];
  logic signed [PW-1:0]       ir_q [NUM_PAIRS];
  logic signed [PW-1:0]       ri_q [NUM_PAIRS];
  logic                       conv1_q, conv2_q;
  logic signed [SW-1:0]       term_q [NUM_TERMS];

  // convention register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_q <= CONV_BH;
    end else if (cfg_i.valid) begin
      conv_q <= cfg_i.data;
    end
  end

  // element view of the input word
  assign re_e[ELEM_A] = amp_i.amp00_re;
  assign im_e[ELEM_A] = amp_i.amp00_im;
  assign re_e[ELEM_B] = amp_i.amp01_re;
  assign im_e[ELEM_B] = amp_i.amp01_im;
  assign re_e[ELEM_C] = amp_i.amp10_re;
  assign im_e[ELEM_C] = amp_i.amp10_im;
  assign re_e[ELEM_D] = amp_i.amp11_re;
  assign im_e[ELEM_D] = amp_i.amp11_im;

  // elastic two-stage pipeline control
  assign adv2        = !s2_valid_q || terms_ready_i;
  assign adv1        = !s1_valid_q || adv2;
  assign amp_i.ready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid_q <= amp_i.valid;
      end
      if (adv2) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // stage 1: squares of every part
  for (genvar e = 0; e < NUM_ELEMS; e++) begin : g_sq
    always_ff @(posedge clk_i) begin
      if (adv1) begin
        sq_re_q[e] <= PW'(re_e[e]) * PW'(re_e[e]);
        sq_im_q[e] <= PW'(im_e[e]) * PW'(im_e[e]);
      end
    end
  end

  // stage 1: cross products of each element pair
  for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_pp
    localparam int unsigned X = pair_x(p);
    localparam int unsigned Y = pair_y(p);
    always_ff @(posedge clk_i) begin
      if (adv1) begin
        rr_q[p] <= PW'(re_e[X]) * PW'(re_e[Y]);
        ii_q[p] <= PW'(im_e[X]) * PW'(im_e[Y]);
        ir_q[p] <= PW'(im_e[X]) * PW'(re_e[Y]);
        ri_q[p] <= PW'(re_e[X]) * PW'(im_e[Y]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      conv1_q <= conv_q;
    end
    if (adv2) begin
      conv2_q <= conv1_q;
    end
  end

  // stage 2: magnitudes
  for (genvar e = 0; e < NUM_ELEMS; e++) begin : g_norm
    always_ff @(posedge clk_i) begin
      if (adv2) begin
        term_q[TERM_NORM0 + e] <= SW'(sq_re_q[e]) + SW'(sq_im_q[e]);
      end
    end
  end

  // stage 2: re and im of x * conj(y)
  for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_cross
    always_ff @(posedge clk_i) begin
      if (adv2) begin
        term_q[TERM_RE0 + p] <= SW'(rr_q[p]) + SW'(ii_q[p]);
        term_q[TERM_IM0 + p] <= SW'(ir_q[p]) - SW'(ri_q[p]);
      end
    end
  end

  // pack terms for the queue
  for (genvar k = 0; k < NUM_TERMS; k++) begin : g_pack
    assign terms_o[k*SW +: SW] = term_q[k];
  end
  assign terms_o[TW-1]  = conv2_q;
  assign terms_valid_o  = s2_valid_q;

endmodule

### rtl/mmfa_fifo.sv
// ----------------------------------------------------------------------------
// mmfa_fifo
// Short first-in first-out queue of term words between front and back.
// ----------------------------------------------------------------------------
module mmfa_fifo import mmfa_pkg::*; #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = MMFA_QUEUE_DEPTH,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             pop_valid_o,
  input  logic             pop_ready_i
);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = store_q[rd_ptr_q];

  // entry write
  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### rtl/mmfa_back.sv
// ----------------------------------------------------------------------------
// mmfa_back
// Walks the four Mueller rows of the head term word, one row per cycle unless
// row_o stalls, combines terms with the convention's signs, registers the row.
// ----------------------------------------------------------------------------
module mmfa_back import mmfa_pkg::*; #(
  parameter int unsigned IN_WIDTH = MMFA_IN_WIDTH,
  localparam int unsigned SW = 2 * IN_WIDTH + 1,
  localparam int unsigned OW = 2 * IN_WIDTH + 2,
  localparam int unsigned AW = 2 * IN_WIDTH + 3,
  localparam int unsigned TW = NUM_TERMS * SW + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [TW-1:0] terms_i,
  input  logic          terms_valid_i,
  output logic          terms_ready_o,
  mmfa_row_if.source    row_o
);

  logic signed [SW-1:0] t [NUM_TERMS];
  logic signed [AW-1:0] n [NUM_ELEMS];
  logic signed [AW-1:0] cr [NUM_PAIRS];
  logic signed [AW-1:0] ci [NUM_PAIRS];
  logic signed [AW-1:0] col [4];
  logic                 neg [4];
  logic signed [OW-1:0] elem_d [4];
  logic signed [OW-1:0] elem_q [4];
  logic                 conv;
  logic [1:0]           row_q, row_out_q;
  logic                 out_valid_q;
  logic                 load;

  // sign-extend a term to accumulator width
  function automatic logic signed [AW-1:0] ext(input logic signed [SW-1:0] v);
    return AW'(v);
  endfunction

  // twice a value that fits below the top bit
  function automatic logic signed [AW-1:0] twice(input logic signed [AW-1:0] v);
    return {v[AW-2:0], 1'b0};
  endfunction

  // clamp to the output range
  function automatic logic signed [OW-1:0] sat(input logic signed [AW-1:0] v);
    if (v[AW-1] != v[AW-2]) begin
      return v[AW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    end
    return v[OW-1:0];
  endfunction

  // unpack the head word
  for (genvar k = 0; k < NUM_TERMS; k++) begin : g_unpack
    assign t[k] = terms_i[k*SW +: SW];
  end
  for (genvar e = 0; e < NUM_ELEMS; e++) begin : g_n
    assign n[e] = ext(t[TERM_NORM0 + e]);
  end
  for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_c
    assign cr[p] = ext(t[TERM_RE0 + p]);
    assign ci[p] = ext(t[TERM_IM0 + p]);
  end
  assign conv = terms_i[TW-1];

  // row combination
  always_comb begin
    unique case (row_q)
      ROW_FIRST: begin
        col[0] = n[ELEM_A] + n[ELEM_B] + n[ELEM_C] + n[ELEM_D];
        col[1] = n[ELEM_A] - n[ELEM_B] + n[ELEM_C] - n[ELEM_D];
        col[2] = twice(cr[PAIR_AB] + cr[PAIR_CD]);
        col[3] = twice(ci[PAIR_AB] + ci[PAIR_CD]);
        neg[0] = 1'b0;
        neg[1] = 1'b0;
        neg[2] = (conv == CONV_TMAT);
        neg[3] = 1'b0;
      end
      ROW_1: begin
        col[0] = n[ELEM_A] + n[ELEM_B] - n[ELEM_C] - n[ELEM_D];
        col[1] = n[ELEM_A] - n[ELEM_B] - n[ELEM_C] + n[ELEM_D];
        col[2] = twice(cr[PAIR_AB] - cr[PAIR_CD]);
        col[3] = twice(ci[PAIR_AB] - ci[PAIR_CD]);
        neg[0] = 1'b0;
        neg[1] = 1'b0;
        neg[2] = (conv == CONV_TMAT);
        neg[3] = 1'b0;
      end
      ROW_2: begin
        col[0] = twice(cr[PAIR_AC] + cr[PAIR_BD]);
        col[1] = twice(cr[PAIR_AC] - cr[PAIR_BD]);
        col[2] = twice(cr[PAIR_AD] + cr[PAIR_BC]);
        col[3] = twice(ci[PAIR_AD] - ci[PAIR_BC]);
        neg[0] = (conv == CONV_TMAT);
        neg[1] = (conv == CONV_TMAT);
        neg[2] = 1'b0;
        neg[3] = (conv == CONV_TMAT);
      end
      ROW_LAST: begin
        col[0] = twice(ci[PAIR_AC] + ci[PAIR_BD]);
        col[1] = twice(ci[PAIR_AC] - ci[PAIR_BD]);
        col[2] = twice(ci[PAIR_AD] + ci[PAIR_BC]);
        col[3] = twice(cr[PAIR_AD] - cr[PAIR_BC]);
        neg[0] = 1'b1;
        neg[1] = 1'b1;
        neg[2] = 1'b1;
        neg[3] = 1'b0;
      end
    endcase
  end

  // sign and clamp
  for (genvar c = 0; c < 4; c++) begin : g_col
    assign elem_d[c] = sat(neg[c] ? -col[c] : col[c]);
  end

  // output register and row counter
  assign load          = terms_valid_i && (!out_valid_q || row_o.ready);
  assign terms_ready_o = load && (row_q == ROW_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      row_q       <= ROW_FIRST;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        row_q       <= row_q + 1'b1;
      end else if (row_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      row_out_q <= row_q;
      elem_q    <= elem_d;
    end
  end

  assign row_o.valid     = out_valid_q;
  assign row_o.row_index = row_out_q;
  assign row_o.elem_col0 = elem_q[0];
  assign row_o.elem_col1 = elem_q[1];
  assign row_o.elem_col2 = elem_q[2];
  assign row_o.elem_col3 = elem_q[3];
  assign row_o.last_row  = (row_out_q == ROW_LAST);

endmodule
